>>> rtl/mcst_pkg.sv
// Shared types, codes and constants of the multi-channel soft timer.
package mcst_pkg;

  localparam int unsigned CFG_W    = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned EVENT_W  = 3;

  // Input item modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_MAX_PERIOD   = 1'b0;
  localparam logic CFG_TICKS_PER_MS = 1'b1;

  localparam logic [CFG_W-1:0] MAX_PERIOD_RST   = 16'd7500;
  localparam logic [CFG_W-1:0] TICKS_PER_MS_RST = 16'd7812;

  // ticks = (ms * ticks_per_ms_milli + 500) / 1000, the divide done as
  // a shift by three and a reciprocal multiply for the remaining 125
  localparam int unsigned PROD_W      = 32;
  localparam logic [PROD_W-1:0] ROUND_HALF = 32'd500;
  localparam int unsigned DIV_PRE     = 3;
  localparam int unsigned DIV_IN_W    = PROD_W - DIV_PRE;
  localparam int unsigned RECIP_W     = 30;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned QUOT_W      = 23;
  localparam logic [RECIP_W-1:0] RECIP_125 = 30'd549755814;

  // At most this many expiry results are reported for one tick
  localparam int unsigned MAX_REPORTS = 4;
  localparam int unsigned REP_CNT_W   = 2;

  typedef enum logic [EVENT_W-1:0] {
    EV_STARTED  = 3'd0,
    EV_TOO_LONG = 3'd1,
    EV_NO_FREE  = 3'd2,
    EV_EXPIRED  = 3'd3,
    EV_STOPPED  = 3'd4
  } event_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              too_long;
    logic              rep;
    logic [CHAN_W-1:0] chan;
    logic [PROD_W-1:0] prod;
  } req_t;

  typedef struct packed {
    logic              load;
    logic              single;
    event_e            ev;
    logic [CHAN_W-1:0] chan;
  } res_load_t;

endpackage

>>> rtl/mcst_front.sv
// Input register: captures an item, checks the period limit and forms the rounded product.
module mcst_front import mcst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [PERIOD_W-1:0] period_ms_i,
  input  logic                repeat_req_i,
  input  logic [CHAN_W-1:0]   channel_i,
  input  logic [CFG_W-1:0]    max_period_ms_i,
  input  logic [CFG_W-1:0]    ticks_per_ms_i,
  input  logic                take_i,
  output logic                req_valid_o,
  output req_t                req_o
);

  logic              req_valid_q;
  req_t              req_q;
  req_t              req_d;
  logic              accept;
  logic [PROD_W-1:0] prod;

  assign in_stall_o = req_valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign prod = PROD_W'(period_ms_i) * PROD_W'(ticks_per_ms_i);

  always_comb begin
    req_d.mode     = mode_i;
    req_d.too_long = (period_ms_i >= max_period_ms_i);
    req_d.rep      = repeat_req_i;
    req_d.chan     = channel_i;
    req_d.prod     = prod + ROUND_HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (accept) begin
      req_valid_q <= 1'b1;
    end else if (take_i) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_d;
    end
  end

  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

endmodule

>>> rtl/mcst_core.sv
// Tick counter and compare channels: executes one item per cycle while results can be handed on.
module mcst_core import mcst_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_valid_i,
  input  req_t                    req_i,
  input  logic                    res_free_i,
  output logic                    take_o,
  output res_load_t               res_ld_o,
  output logic [NUM_CHANNELS-1:0] exp_mask_o
);

  localparam int unsigned CIDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned MUL_W  = DIV_IN_W + RECIP_W;
  localparam int unsigned EXT_W  = QUOT_W + COUNT_WIDTH;

  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic [NUM_CHANNELS-1:0] active_q, active_d;
  logic [NUM_CHANNELS-1:0] periodic_q, periodic_d;
  logic [COUNT_WIDTH-1:0] period_ticks_q [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] period_ticks_d [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] compare_q [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0] compare_d [NUM_CHANNELS];

  logic [MUL_W-1:0]       recip_prod;
  logic [QUOT_W-1:0]      quot;
  logic [EXT_W-1:0]       quot_ext;
  logic [COUNT_WIDTH-1:0] ticks;
  logic                   found;
  logic [CIDX_W-1:0]      free_idx;
  logic                   stop_ok;
  res_load_t              res_ld;
  logic [NUM_CHANNELS-1:0] exp_mask;

  assign take_o = req_valid_i & res_free_i;

  // divide by 1000: shift out the factor eight, multiply by the reciprocal of 125
  assign recip_prod = {RECIP_W'(0), req_i.prod[PROD_W-1:DIV_PRE]} *
                      {DIV_IN_W'(0), RECIP_125};
  assign quot     = recip_prod[RECIP_SHIFT +: QUOT_W];
  assign quot_ext = {COUNT_WIDTH'(0), quot};
  // saturate a tick count beyond the counter range
  assign ticks    = (|(quot_ext >> COUNT_WIDTH)) ? '1 : quot_ext[COUNT_WIDTH-1:0];

  assign cnt_inc = cnt_q + COUNT_WIDTH'(1);
  assign stop_ok = (int'(req_i.chan) < NUM_CHANNELS);

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        found    = 1'b1;
        free_idx = CIDX_W'(i);
      end
    end
  end

  always_comb begin
    cnt_d          = cnt_q;
    active_d       = active_q;
    periodic_d     = periodic_q;
    period_ticks_d = period_ticks_q;
    compare_d      = compare_q;
    exp_mask       = '0;
    res_ld.load    = 1'b0;
    res_ld.single  = 1'b1;
    res_ld.ev      = EV_STOPPED;
    res_ld.chan    = '0;
    case (req_i.mode)
      MODE_TICK: begin
        cnt_d = cnt_inc;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (active_q[i] && compare_q[i] == cnt_inc) begin
            exp_mask[i] = 1'b1;
            if (periodic_q[i]) begin
              compare_d[i] = cnt_inc + period_ticks_q[i];
            end else begin
              active_d[i] = 1'b0;
            end
          end
        end
        res_ld.load   = |exp_mask;
        res_ld.single = 1'b0;
        res_ld.ev     = EV_EXPIRED;
      end
      MODE_START: begin
        res_ld.load = 1'b1;
        if (req_i.too_long) begin
          res_ld.ev = EV_TOO_LONG;
        end else if (!found) begin
          res_ld.ev = EV_NO_FREE;
        end else begin
          active_d[free_idx]       = 1'b1;
          periodic_d[free_idx]     = req_i.rep;
          period_ticks_d[free_idx] = ticks;
          compare_d[free_idx]      = cnt_q + ticks;
          res_ld.ev                = EV_STARTED;
          res_ld.chan              = CHAN_W'(free_idx);
        end
      end
      MODE_STOP: begin
        res_ld.load = 1'b1;
        res_ld.ev   = EV_STOPPED;
        res_ld.chan = req_i.chan;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (stop_ok && int'(req_i.chan) == i) begin
            active_d[i] = 1'b0;
          end
        end
      end
      default: begin
        // unused mode: drop the item
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      active_q   <= '0;
      periodic_q <= '0;
    end else if (take_o) begin
      cnt_q      <= cnt_d;
      active_q   <= active_d;
      periodic_q <= periodic_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      period_ticks_q <= period_ticks_d;
      compare_q      <= compare_d;
    end
  end

  always_comb begin
    res_ld_o      = res_ld;
    res_ld_o.load = res_ld.load & take_o;
  end

  assign exp_mask_o = exp_mask;

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && req_i.mode == MODE_TICK |=> cnt_q == $past(cnt_q) + COUNT_WIDTH'(1))
    else $error("tick did not advance the counter by one");

  a_expiry_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_mask & ~active_q) == '0)
    else $error("expiry reported on a free channel");

endmodule

>>> rtl/mcst_resq.sv
// Result register: holds one result or a burst of expiries and drains them in order.
module mcst_resq import mcst_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  res_load_t               res_ld_i,
  input  logic [NUM_CHANNELS-1:0] exp_mask_i,
  output logic                    res_free_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [EVENT_W-1:0]      event_res_o,
  output logic [CHAN_W-1:0]       channel_id_o,
  output logic                    last_o
);

  logic                    busy_q;
  logic [REP_CNT_W-1:0]    cnt_q;
  logic                    single_q;
  event_e                  ev_q;
  logic [CHAN_W-1:0]       chan_q;
  logic [NUM_CHANNELS-1:0] mask_q;

  logic [NUM_CHANNELS-1:0] low_bit;
  logic [NUM_CHANNELS-1:0] rest;
  logic [CHAN_W-1:0]       low_ch;
  logic                    last;
  logic                    xfer;

  assign low_bit = mask_q & (~mask_q + NUM_CHANNELS'(1));
  assign rest    = mask_q & ~low_bit;

  always_comb begin
    low_ch = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        low_ch = CHAN_W'(i);
      end
    end
  end

  // a burst ends when no expiry is left or the report cap is reached
  assign last = single_q | (rest == '0) | (cnt_q == REP_CNT_W'(MAX_REPORTS - 1));
  assign xfer = busy_q & ~out_stall_i;
  assign res_free_o = ~busy_q | (xfer & last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (res_ld_i.load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (xfer) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + REP_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ld_i.load) begin
      single_q <= res_ld_i.single;
      ev_q     <= res_ld_i.ev;
      chan_q   <= res_ld_i.chan;
      mask_q   <= exp_mask_i;
    end else if (xfer && !last) begin
      mask_q <= rest;
    end
  end

  assign out_valid_o  = busy_q;
  assign event_res_o  = single_q ? ev_q : EV_EXPIRED;
  assign channel_id_o = single_q ? chan_q : low_ch;
  assign last_o       = last;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ld_i.load |-> res_free_o)
    else $error("result loaded over a pending result");

  a_burst_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !single_q |-> mask_q != '0)
    else $error("expiry burst pending with no channel left");

  a_burst_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !last && !res_ld_i.load |=> busy_q && cnt_q == $past(cnt_q) + REP_CNT_W'(1))
    else $error("expiry burst did not advance");

endmodule

>>> rtl/multi_channel_soft_timer.sv
// Multi-channel soft timer: configuration registers and the input, channel and result stages.
//
// Usage: items enter on the input channel (in_valid_i / in_stall_o) with a mode: tick,
// start or stop. Results leave on the output channel (out_valid_o / out_stall_i); last_o
// marks the final result of an item. A start reports started, period too long or no
// free channel; a stop reports stopped; a tick reports each expiring channel, lowest
// first, at most four, and an item with no result (quiet tick, unused mode) is dropped.
// An accepted item is held in the input register and its results in the result register.
// Throughput: one item per cycle while each item yields at most one result and the
// receiver takes it; a tick that yields more than one expiry holds the next item in the input
// register while the single result register drains them, one per cycle unless stalled.
// The period conversion uses one multiplier in the input stage and one in the channel
// stage. When the receiver stalls, the result register holds its payload and the input
// register fills, then in_stall_o rises. Reset clears the counter, frees all channels
// and loads the configuration defaults (7500 ms limit, 7.812 ticks per ms); there is
// no clearing pass. Write configuration only while the block is idle.
module multi_channel_soft_timer import mcst_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 4,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [PERIOD_W-1:0] period_ms_i,
  input  logic                repeat_req_i,
  input  logic [CHAN_W-1:0]   channel_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [EVENT_W-1:0]  event_res_o,
  output logic [CHAN_W-1:0]   channel_id_o,
  output logic                last_o
);

  logic [CFG_W-1:0]        max_period_q;
  logic [CFG_W-1:0]        ticks_per_ms_q;
  logic                    take;
  logic                    req_valid;
  req_t                    req;
  logic                    res_free;
  res_load_t               res_ld;
  logic [NUM_CHANNELS-1:0] exp_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_period_q   <= MAX_PERIOD_RST;
      ticks_per_ms_q <= TICKS_PER_MS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_PERIOD:   max_period_q   <= cfg_data_i;
        CFG_TICKS_PER_MS: ticks_per_ms_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  mcst_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .period_ms_i     (period_ms_i),
    .repeat_req_i    (repeat_req_i),
    .channel_i       (channel_i),
    .max_period_ms_i (max_period_q),
    .ticks_per_ms_i  (ticks_per_ms_q),
    .take_i          (take),
    .req_valid_o     (req_valid),
    .req_o           (req)
  );

  mcst_core #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .res_free_i  (res_free),
    .take_o      (take),
    .res_ld_o    (res_ld),
    .exp_mask_o  (exp_mask)
  );

  mcst_resq #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_resq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_ld_i     (res_ld),
    .exp_mask_i   (exp_mask),
    .res_free_o   (res_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_res_o  (event_res_o),
    .channel_id_o (channel_id_o),
    .last_o       (last_o)
  );

endmodule
